// ----- design/cgl_pkg.sv -----
// Shared constants, types and helpers for the colour gradient lookup.
package cgl_pkg;

	localparam int MaxStops = 6;
	localparam int MaxSteps = 1024;
	localparam int IdxW     = 32;
	localparam int StepW    = $clog2(MaxSteps) + 1;
	localparam int PosW     = $clog2(MaxSteps);
	localparam int RemW     = $clog2((MaxStops - 1) * MaxSteps);
	localparam int CntW     = 3;
	localparam int SegW     = 3;
	localparam int ChW      = 8;
	localparam int NumCh    = 3;
	localparam int ColW     = NumCh * ChW;
	localparam int RegIdxW  = 3;
	localparam int VW       = ChW + PosW;
	localparam int DivW     = PosW + ChW - 1;

	typedef enum logic [RegIdxW-1:0] {
		REG_STOP_COUNT = 3'd0,
		REG_STEPS      = 3'd1,
		REG_STOP_A     = 3'd2,
		REG_STOP_B     = 3'd3,
		REG_STOP_C     = 3'd4,
		REG_STOP_D     = 3'd5,
		REG_STOP_E     = 3'd6,
		REG_STOP_F     = 3'd7
	} reg_idx_t;

	typedef logic [MaxStops-1:0][ColW-1:0] stops_t;
	typedef logic [NumCh-1:0][VW-1:0]      vec_t;
	typedef logic [NumCh-1:0][ChW-1:0]     quo_t;

	typedef struct packed {
		logic [RemW-1:0]  total;
		logic [StepW-1:0] n;
		logic [RemW-1:0]  n2;
		logic [RemW-1:0]  n3;
		logic [RemW-1:0]  n4;
		logic [PosW-1:0]  den;
		logic             one_step;
	} geom_t;

	function automatic geom_t geom_of(input logic [CntW-1:0] cnt, input logic [StepW-1:0] steps);
		logic [CntW-1:0]  sc;
		logic [StepW-1:0] nc;
		logic [RemW-1:0]  nw;
		geom_t            g;
		if (cnt < CntW'(2)) sc = CntW'(2);
		else if (cnt > CntW'(MaxStops)) sc = CntW'(MaxStops);
		else sc = cnt;
		if (steps == '0) nc = StepW'(1);
		else if (steps > StepW'(MaxSteps)) nc = StepW'(MaxSteps);
		else nc = steps;
		nw         = RemW'(nc);
		g.total    = RemW'(RemW'(sc - CntW'(1)) * nw);
		g.n        = nc;
		g.n2       = RemW'(nw << 1);
		g.n3       = RemW'((nw << 1) + nw);
		g.n4       = RemW'(nw << 2);
		g.den      = PosW'(nc - StepW'(1));
		g.one_step = (nc == StepW'(1));
		return g;
	endfunction

endpackage

// ----- design/cgl_if.sv -----
// Channel interfaces: configuration writes, index requests, colour results.
interface cgl_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [cgl_pkg::RegIdxW-1:0] index;
	logic [cgl_pkg::ColW-1:0]    data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

interface cgl_in_if;
	logic                     valid;
	logic                     ready;
	logic [cgl_pkg::IdxW-1:0] color_index;
	modport source(output valid, color_index, input ready);
	modport sink(input valid, color_index, output ready);
endinterface

interface cgl_out_if;
	logic                    valid;
	logic                    ready;
	logic [cgl_pkg::ChW-1:0] red;
	logic [cgl_pkg::ChW-1:0] green;
	logic [cgl_pkg::ChW-1:0] blue;
	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

// ----- design/color_gradient_lookup.sv -----
// Top level: configuration registers and the chain of wrap, split, mix and divide cells.
//
//  port   dir  moves           payload
//  cfg    in   register write  index[2:0], data[23:0]
//  pixel  in   index request   color_index[31:0]
//  color  out  rgb result      red, green, blue [7:0]
//
// One request per cycle unless color stalls; the chain is 32 wrap cells (one index bit each),
// the segment split, the mix stage and 8 divide cells (one quotient bit each).
// Every cell holds one request with its own valid flag; a stall at color backs up
// cell by cell, so bubbles close and intake stops only once every cell is full.
// Reset clears the cell valid flags and loads the register reset values.
module color_gradient_lookup import cgl_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	cgl_cfg_if.sink  cfg,
	cgl_in_if.sink   pixel,
	cgl_out_if.source color
);
	localparam int ModCells = IdxW;
	localparam int DivCells = ChW;

	logic [CntW-1:0]  stop_count_q;
	logic [StepW-1:0] steps_q;
	stops_t           stops_q;
	geom_t            geom;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_count_q <= CntW'(2);
			steps_q      <= StepW'(256);
			stops_q      <= {{(MaxStops-2){ColW'(0)}}, {ColW{1'b1}}, ColW'(0)};
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_STOP_COUNT: stop_count_q <= cfg.data[CntW-1:0];
				REG_STEPS:      steps_q      <= cfg.data[StepW-1:0];
				REG_STOP_A:     stops_q[0]   <= cfg.data;
				REG_STOP_B:     stops_q[1]   <= cfg.data;
				REG_STOP_C:     stops_q[2]   <= cfg.data;
				REG_STOP_D:     stops_q[3]   <= cfg.data;
				REG_STOP_E:     stops_q[4]   <= cfg.data;
				REG_STOP_F:     stops_q[5]   <= cfg.data;
				default: ;
			endcase
		end
	end

	assign geom = geom_of(stop_count_q, steps_q);

	logic [ModCells:0]           m_valid;
	logic [ModCells:0]           m_ready;
	logic [ModCells:0][IdxW-1:0] m_idx;
	logic [ModCells:0][RemW-1:0] m_rem;

	assign m_valid[0]  = pixel.valid;
	assign pixel.ready = m_ready[0];
	assign m_idx[0]    = pixel.color_index;
	assign m_rem[0]    = '0;

	for (genvar k = 0; k < ModCells; k++) begin : g_mod
		cgl_mod_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.geom    (geom),
			.up_valid(m_valid[k]),
			.up_ready(m_ready[k]),
			.up_idx  (m_idx[k]),
			.up_rem  (m_rem[k]),
			.dn_valid(m_valid[k+1]),
			.dn_ready(m_ready[k+1]),
			.dn_idx  (m_idx[k+1]),
			.dn_rem  (m_rem[k+1])
		);
	end

	logic            s_valid;
	logic            s_ready;
	logic [PosW-1:0] s_pos;
	logic [ColW-1:0] s_c1;
	logic [ColW-1:0] s_c2;

	cgl_seg u_seg (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom),
		.stops   (stops_q),
		.up_valid(m_valid[ModCells]),
		.up_ready(m_ready[ModCells]),
		.up_rem  (m_rem[ModCells]),
		.dn_valid(s_valid),
		.dn_ready(s_ready),
		.dn_pos  (s_pos),
		.dn_c1   (s_c1),
		.dn_c2   (s_c2)
	);

	logic [DivCells:0]           d_valid;
	logic [DivCells:0]           d_ready;
	vec_t [DivCells:0]           d_r;
	quo_t [DivCells:0]           d_q;
	logic [DivCells:0][ColW-1:0] d_c1;

	assign d_q[0] = '0;

	cgl_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom),
		.up_valid(s_valid),
		.up_ready(s_ready),
		.up_pos  (s_pos),
		.up_c1   (s_c1),
		.up_c2   (s_c2),
		.dn_valid(d_valid[0]),
		.dn_ready(d_ready[0]),
		.dn_v    (d_r[0]),
		.dn_c1   (d_c1[0])
	);

	for (genvar k = 0; k < DivCells; k++) begin : g_div
		cgl_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.geom    (geom),
			.up_valid(d_valid[k]),
			.up_ready(d_ready[k]),
			.up_r    (d_r[k]),
			.up_q    (d_q[k]),
			.up_c1   (d_c1[k]),
			.dn_valid(d_valid[k+1]),
			.dn_ready(d_ready[k+1]),
			.dn_r    (d_r[k+1]),
			.dn_q    (d_q[k+1]),
			.dn_c1   (d_c1[k+1])
		);
	end

	assign color.valid       = d_valid[DivCells];
	assign d_ready[DivCells] = color.ready;
	assign color.red   = geom.one_step ? d_c1[DivCells][2*ChW +: ChW] : d_q[DivCells][2];
	assign color.green = geom.one_step ? d_c1[DivCells][ChW +: ChW]   : d_q[DivCells][1];
	assign color.blue  = geom.one_step ? d_c1[DivCells][0 +: ChW]     : d_q[DivCells][0];
endmodule

// ----- design/cgl_mod_cell.sv -----
// One bit of the index wrap: shift in an index bit, subtract the length if it fits.
module cgl_mod_cell import cgl_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  geom_t           geom,
	input  logic            up_valid,
	output logic            up_ready,
	input  logic [IdxW-1:0] up_idx,
	input  logic [RemW-1:0] up_rem,
	output logic            dn_valid,
	input  logic            dn_ready,
	output logic [IdxW-1:0] dn_idx,
	output logic [RemW-1:0] dn_rem
);
	logic [RemW:0]   trial;
	logic [RemW:0]   nxt;
	logic            valid_q;
	logic [IdxW-1:0] idx_q;
	logic [RemW-1:0] rem_q;

	assign up_ready = !valid_q || dn_ready;
	assign trial    = {up_rem, up_idx[IdxW-1]};
	assign nxt      = (trial >= {1'b0, geom.total}) ? trial - {1'b0, geom.total} : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			idx_q <= {up_idx[IdxW-2:0], 1'b0};
			rem_q <= nxt[RemW-1:0];
		end
	end

	assign dn_valid = valid_q;
	assign dn_idx   = idx_q;
	assign dn_rem   = rem_q;
endmodule

// ----- design/cgl_seg.sv -----
// Segment split: picks the stop pair and the position inside the segment.
module cgl_seg import cgl_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  geom_t           geom,
	input  stops_t          stops,
	input  logic            up_valid,
	output logic            up_ready,
	input  logic [RemW-1:0] up_rem,
	output logic            dn_valid,
	input  logic            dn_ready,
	output logic [PosW-1:0] dn_pos,
	output logic [ColW-1:0] dn_c1,
	output logic [ColW-1:0] dn_c2
);
	logic [SegW-1:0] seg;
	logic [SegW-1:0] seg_nx;
	logic [RemW-1:0] base;
	logic [RemW-1:0] pos_w;
	logic            valid_q;
	logic [PosW-1:0] pos_q;
	logic [ColW-1:0] c1_q;
	logic [ColW-1:0] c2_q;

	always_comb begin
		priority if (up_rem >= geom.n4) begin
			seg  = SegW'(4);
			base = geom.n4;
		end else if (up_rem >= geom.n3) begin
			seg  = SegW'(3);
			base = geom.n3;
		end else if (up_rem >= geom.n2) begin
			seg  = SegW'(2);
			base = geom.n2;
		end else if (up_rem >= RemW'(geom.n)) begin
			seg  = SegW'(1);
			base = RemW'(geom.n);
		end else begin
			seg  = SegW'(0);
			base = '0;
		end
	end

	assign seg_nx   = seg + SegW'(1);
	assign pos_w    = up_rem - base;
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			pos_q <= pos_w[PosW-1:0];
			c1_q  <= stops[seg];
			c2_q  <= stops[seg_nx];
		end
	end

	assign dn_valid = valid_q;
	assign dn_pos   = pos_q;
	assign dn_c1    = c1_q;
	assign dn_c2    = c2_q;
endmodule

// ----- design/cgl_mix.sv -----
// Weighted sum of the two stops, one small product pair per channel.
module cgl_mix import cgl_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  geom_t           geom,
	input  logic            up_valid,
	output logic            up_ready,
	input  logic [PosW-1:0] up_pos,
	input  logic [ColW-1:0] up_c1,
	input  logic [ColW-1:0] up_c2,
	output logic            dn_valid,
	input  logic            dn_ready,
	output vec_t            dn_v,
	output logic [ColW-1:0] dn_c1
);
	logic [PosW-1:0] w1;
	vec_t            v;
	logic            valid_q;
	vec_t            v_q;
	logic [ColW-1:0] c1_q;

	assign w1       = geom.den - up_pos;
	assign up_ready = !valid_q || dn_ready;

	always_comb begin
		for (int ch = 0; ch < NumCh; ch++) begin
			v[ch] = VW'(up_c1[ch*ChW +: ChW]) * VW'(w1) + VW'(up_c2[ch*ChW +: ChW]) * VW'(up_pos);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			v_q  <= v;
			c1_q <= up_c1;
		end
	end

	assign dn_valid = valid_q;
	assign dn_v     = v_q;
	assign dn_c1    = c1_q;
endmodule

// ----- design/cgl_div_cell.sv -----
// One quotient bit of the divide by steps-1, all three channels side by side.
module cgl_div_cell import cgl_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  geom_t           geom,
	input  logic            up_valid,
	output logic            up_ready,
	input  vec_t            up_r,
	input  quo_t            up_q,
	input  logic [ColW-1:0] up_c1,
	output logic            dn_valid,
	input  logic            dn_ready,
	output vec_t            dn_r,
	output quo_t            dn_q,
	output logic [ColW-1:0] dn_c1
);
	logic [DivW-1:0] dvs;
	vec_t            r_nx;
	quo_t            q_nx;
	logic [VW-1:0]   diff;
	logic            ge;
	logic            valid_q;
	vec_t            r_q;
	quo_t            q_q;
	logic [ColW-1:0] c1_q;

	assign dvs      = {geom.den, {(ChW-1){1'b0}}};
	assign up_ready = !valid_q || dn_ready;

	always_comb begin
		for (int ch = 0; ch < NumCh; ch++) begin
			ge       = up_r[ch] >= VW'(dvs);
			diff     = ge ? up_r[ch] - VW'(dvs) : up_r[ch];
			r_nx[ch] = {diff[VW-2:0], 1'b0};
			q_nx[ch] = {up_q[ch][ChW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			r_q  <= r_nx;
			q_q  <= q_nx;
			c1_q <= up_c1;
		end
	end

	assign dn_valid = valid_q;
	assign dn_r     = r_q;
	assign dn_q     = q_q;
	assign dn_c1    = c1_q;
endmodule
